// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned OP_BITS   = 3;
  localparam int unsigned ST_BITS   = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer: idle takes a word, fetch waits on the RAM read after a pop
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } seq_e;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] popped_word;
    status_e                     status;
    logic [CNT_BITS-1:0]         entry_count;
    logic                        is_empty;
    logic signed [WORD_BITS-1:0] front_word;
    logic signed [WORD_BITS-1:0] back_word;
  } result_t;

endpackage

// ===== sv/deq_if.sv =====
`timescale 1ns / 1ps

interface deq_req_if import deq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          operation;
  logic signed [WORD_BITS-1:0] push_word;

  modport source (output valid, output operation, output push_word, input ready);
  modport sink   (input valid, input operation, input push_word, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] popped_word;
  logic [ST_BITS-1:0]          status;
  logic [CNT_BITS-1:0]         entry_count;
  logic                        is_empty;
  logic signed [WORD_BITS-1:0] front_word;
  logic signed [WORD_BITS-1:0] back_word;

  modport source (output valid, output popped_word, output status, output entry_count,
                  output is_empty, output front_word, output back_word, input ready);
  modport sink   (input valid, input popped_word, input status, input entry_count,
                  input is_empty, input front_word, input back_word, output ready);
endinterface

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Timing: a result is registered into the output stage, or the skid stage while the
//   output is held; a pop leaving two or more words first reads the new end from RAM.
// Throughput: one word per cycle while the skid stage is free; such pops hold off new
//   words in the fetch state, since the word store has a single registered read port.
// Reset: asynchronous, clears pointers, count, sequencer and output valids;
//   the word store is not cleared (no clearing pass).

module double_ended_queue import deq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  deq_req_if.sink      req_i,
  deq_rsp_if.source    rsp_o
);

  // modular pointer steps, valid for any depth
  function automatic logic [IDX_BITS-1:0] idx_inc(input logic [IDX_BITS-1:0] i);
    return (i == IDX_BITS'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_BITS-1:0] idx_dec(input logic [IDX_BITS-1:0] i);
    return (i == '0) ? IDX_BITS'(DEPTH - 1) : i - 1'b1;
  endfunction

  // sequencer and queue state
  seq_e                  state_q, state_d;
  logic [IDX_BITS-1:0]   front_idx_q, front_idx_d;
  logic [IDX_BITS-1:0]   back_idx_q, back_idx_d;
  logic [CNT_BITS-1:0]   count_q, count_d;

  // end words are cached so only a pop that leaves two or more words waits on the RAM for them
  logic [WORD_BITS-1:0]  front_q, front_d;
  logic [WORD_BITS-1:0]  back_q, back_d;

  // pending fetch: which end is refilled, and the popped word held meanwhile
  logic                  fetch_front_q, fetch_front_d;
  logic [WORD_BITS-1:0]  popped_q, popped_d;

  // output register plus skid stage
  result_t               out_q, skid_q;
  logic                  out_vld_q, skid_vld_q;

  // RAM port
  logic                  ram_we, ram_re;
  logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  logic                  accept;
  logic                  drain;
  logic                  res_vld;
  logic [WORD_BITS-1:0]  res_popped;
  status_e               res_status;
  result_t               res;

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // new words only while idle and the skid is free, so every result has a place
  assign req_i.ready = (state_q == S_IDLE) && !skid_vld_q;
  assign accept      = req_i.valid && req_i.ready;
  assign drain       = out_vld_q && rsp_o.ready;

  always_comb begin
    state_d       = state_q;
    front_idx_d   = front_idx_q;
    back_idx_d    = back_idx_q;
    count_d       = count_q;
    front_d       = front_q;
    back_d        = back_q;
    fetch_front_d = fetch_front_q;
    popped_d      = popped_q;
    ram_we        = 1'b0;
    ram_waddr     = front_idx_q;
    ram_wdata     = req_i.push_word;
    ram_re        = 1'b0;
    ram_raddr     = front_idx_q;
    res_vld       = 1'b0;
    res_popped    = '0;
    res_status    = ST_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_vld = 1'b1;
          unique case (op_e'(req_i.operation))
            OP_PUSH_FRONT: begin
              if (count_q == CNT_BITS'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = idx_dec(front_idx_q);
                front_idx_d = idx_dec(front_idx_q);
                count_d     = count_q + 1'b1;
                front_d     = req_i.push_word;
                if (count_q == '0) begin
                  back_d = req_i.push_word;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (count_q == CNT_BITS'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = idx_inc(back_idx_q);
                back_idx_d = idx_inc(back_idx_q);
                count_d    = count_q + 1'b1;
                back_d     = req_i.push_word;
                if (count_q == '0) begin
                  front_d = req_i.push_word;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count_q == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_popped  = front_q;
                front_idx_d = idx_inc(front_idx_q);
                count_d     = count_q - 1'b1;
                if (count_q == CNT_BITS'(2)) begin
                  front_d = back_q;
                end else if (count_q > CNT_BITS'(2)) begin
                  // new front lies only in the store
                  ram_re        = 1'b1;
                  ram_raddr     = idx_inc(front_idx_q);
                  fetch_front_d = 1'b1;
                  popped_d      = front_q;
                  res_vld       = 1'b0;
                  state_d       = S_FETCH;
                end
              end
            end
            OP_POP_BACK: begin
              if (count_q == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_popped = back_q;
                back_idx_d = idx_dec(back_idx_q);
                count_d    = count_q - 1'b1;
                if (count_q == CNT_BITS'(2)) begin
                  back_d = front_q;
                end else if (count_q > CNT_BITS'(2)) begin
                  ram_re        = 1'b1;
                  ram_raddr     = idx_dec(back_idx_q);
                  fetch_front_d = 1'b0;
                  popped_d      = back_q;
                  res_vld       = 1'b0;
                  state_d       = S_FETCH;
                end
              end
            end
            default: begin
              // query, and the unused codes which behave alike
            end
          endcase
        end
      end
      S_FETCH: begin
        res_vld    = 1'b1;
        res_popped = popped_q;
        if (fetch_front_q) begin
          front_d = ram_rdata;
        end else begin
          back_d = ram_rdata;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result reflects the state after the operation
  always_comb begin
    res.popped_word = res_popped;
    res.status      = res_status;
    res.entry_count = count_d;
    res.is_empty    = (count_d == '0);
    res.front_word  = (count_d == '0) ? '0 : front_d;
    res.back_word   = (count_d == '0) ? '0 : back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      front_idx_q   <= '0;
      back_idx_q    <= IDX_BITS'(DEPTH - 1);
      count_q       <= '0;
      fetch_front_q <= 1'b0;
      out_vld_q     <= 1'b0;
      skid_vld_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      front_idx_q   <= front_idx_d;
      back_idx_q    <= back_idx_d;
      count_q       <= count_d;
      fetch_front_q <= fetch_front_d;
      if (drain || !out_vld_q) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= res_vld;
        end else begin
          out_vld_q  <= res_vld;
        end
      end else if (res_vld) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // payload: end-word cache and output words
  always_ff @(posedge clk_i) begin
    front_q  <= front_d;
    back_q   <= back_d;
    popped_q <= popped_d;
    if (drain || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.popped_word = out_q.popped_word;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.entry_count = out_q.entry_count;
  assign rsp_o.is_empty    = out_q.is_empty;
  assign rsp_o.front_word  = out_q.front_word;
  assign rsp_o.back_word   = out_q.back_word;

  // skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage valid with output register empty");

  // count stays within the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("held count beyond depth");

  // a fetch always follows an accepted pop that reads the store
  a_fetch_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ram_re |=> state_q == S_FETCH)
    else $error("store read without fetch cycle");

  // a result never arrives with both output stages full and held
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && skid_vld_q |-> drain)
    else $error("result lost: output stages full");

  // the store is never written and read in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store written and read together");

endmodule

// ===== sv/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
